/* hw/rtl/prlp_pkg.sv */
// ----------------------------------------------------------------------------
// prlp_pkg: shared types and constants of the request line parser
// Phase codes, result layout, byte classes and the "GET " prefix.
// ----------------------------------------------------------------------------
package prlp_pkg;

   localparam int BYTE_BITS     = 8;
   localparam int IMAGE_BITS    = 32;
   localparam int PORT_BITS     = 16;
   localparam int DIGIT_BITS    = 4;
   localparam int RSP_DATA_BITS = 56;   // 1 + 32 + 16 = 49, padded to 7 bytes

   localparam logic [BYTE_BITS-1:0] CHAR_SPACE = 8'h20;
   localparam logic [BYTE_BITS-1:0] CHAR_LF    = 8'h0A;
   localparam logic [BYTE_BITS-1:0] CHAR_CR    = 8'h0D;
   localparam logic [BYTE_BITS-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [BYTE_BITS-1:0] CHAR_NINE  = 8'h39;

   localparam logic STATUS_OK     = 1'b0;
   localparam logic STATUS_REJECT = 1'b1;

   localparam logic [1:0] PREFIX_LAST   = 2'd3;
   localparam logic [1:0] NEWLINES_DONE = 2'd2;

   typedef enum logic [2:0] {
      PH_PREFIX   = 3'd0,
      PH_IMAGE    = 3'd1,
      PH_SKIP     = 3'd2,
      PH_PORT     = 3'd3,
      PH_NEWLINES = 3'd4
   } phase_type;

   typedef struct packed {
      logic                  status;
      logic [IMAGE_BITS-1:0] image_number;
      logic [PORT_BITS-1:0]  reply_port;
   } result_type;

   function automatic logic [BYTE_BITS-1:0] prefix_char(input logic [1:0] pos);
      logic [BYTE_BITS-1:0] c;
      unique case (pos)
         2'd0:    c = 8'h47;   // G
         2'd1:    c = 8'h45;   // E
         2'd2:    c = 8'h54;   // T
         default: c = CHAR_SPACE;
      endcase
      return c;
   endfunction

   function automatic logic [DIGIT_BITS-1:0] digit_of(input logic [BYTE_BITS-1:0] b);
      logic [BYTE_BITS-1:0] diff;
      diff = b - CHAR_ZERO;
      if (b >= CHAR_ZERO && b <= CHAR_NINE) begin
         return diff[DIGIT_BITS-1:0];
      end
      return '0;
   endfunction

   function automatic logic ends_number(input logic [BYTE_BITS-1:0] b);
      return (b == CHAR_SPACE) || (b == CHAR_LF) || (b == CHAR_CR);
   endfunction

endpackage

/* hw/rtl/prlp_mac10.sv */
// ----------------------------------------------------------------------------
// prlp_mac10: saturating decimal accumulate
// Computes acc * 10 + digit, clamped to the all-ones value of WIDTH bits.
// ----------------------------------------------------------------------------
module prlp_mac10 #(
   parameter int WIDTH = 32
) (
   input  logic [WIDTH-1:0]                acc,
   input  logic [prlp_pkg::DIGIT_BITS-1:0] digit,
   output logic [WIDTH-1:0]                sum
);

   localparam int WIDE = WIDTH + 4;   // acc * 10 + 9 fits in four more bits

   logic [WIDE-1:0] acc_wide;
   logic [WIDE-1:0] prod;

   // times ten as times eight plus times two
   assign acc_wide = {4'b0000, acc};
   assign prod     = (acc_wide << 3) + (acc_wide << 1)
                   + {{(WIDE-prlp_pkg::DIGIT_BITS){1'b0}}, digit};
   assign sum      = (prod[WIDE-1:WIDTH] != 4'b0000) ? {WIDTH{1'b1}} : prod[WIDTH-1:0];

endmodule

/* hw/rtl/prlp_core.sv */
// ----------------------------------------------------------------------------
// prlp_core: request line state and per-byte step
// Holds the parse state, works out one byte's effect and the result it makes.
// ----------------------------------------------------------------------------
module prlp_core #(
   parameter int NUMBER_BITS = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic [prlp_pkg::BYTE_BITS-1:0]     byte_in,
   input  logic                               fire,
   output logic                               emit,
   output prlp_pkg::result_type               result
);

   prlp_pkg::phase_type           phase_ff,  phase_in;
   logic [1:0]                    pos_ff,    pos_in;
   logic                          ok_ff,     ok_in;
   logic [NUMBER_BITS-1:0]        number_ff, number_in;
   logic [prlp_pkg::PORT_BITS-1:0] port_ff,  port_in;
   logic [1:0]                    nl_ff,     nl_in;

   logic [prlp_pkg::DIGIT_BITS-1:0] digit;
   logic [NUMBER_BITS-1:0]          number_mac;
   logic [prlp_pkg::PORT_BITS-1:0]  port_mac;
   logic [1:0]                      nl_next;
   logic                            ok_next;
   logic [prlp_pkg::IMAGE_BITS-1:0] image_clamped;

   assign digit   = prlp_pkg::digit_of(byte_in);
   assign nl_next = nl_ff + {1'b0, (byte_in == prlp_pkg::CHAR_LF)};
   assign ok_next = ok_ff && (byte_in == prlp_pkg::prefix_char(pos_ff));

   prlp_mac10 #(.WIDTH(NUMBER_BITS)) u_number_mac (
      .acc   (number_ff),
      .digit (digit),
      .sum   (number_mac)
   );

   prlp_mac10 #(.WIDTH(prlp_pkg::PORT_BITS)) u_port_mac (
      .acc   (port_ff),
      .digit (digit),
      .sum   (port_mac)
   );

   // Clamp the accumulator to the 32-bit result field
   generate
      if (NUMBER_BITS > prlp_pkg::IMAGE_BITS) begin : g_clamp
         assign image_clamped = (|number_ff[NUMBER_BITS-1:prlp_pkg::IMAGE_BITS])
                              ? {prlp_pkg::IMAGE_BITS{1'b1}}
                              : number_ff[prlp_pkg::IMAGE_BITS-1:0];
      end else if (NUMBER_BITS == prlp_pkg::IMAGE_BITS) begin : g_same
         assign image_clamped = number_ff;
      end else begin : g_extend
         assign image_clamped = {{(prlp_pkg::IMAGE_BITS-NUMBER_BITS){1'b0}}, number_ff};
      end
   endgenerate

   always_comb begin
      phase_in  = phase_ff;
      pos_in    = pos_ff;
      ok_in     = ok_ff;
      number_in = number_ff;
      port_in   = port_ff;
      nl_in     = nl_ff;
      emit      = 1'b0;
      result.status       = prlp_pkg::STATUS_OK;
      result.image_number = image_clamped;
      result.reply_port   = port_ff;
      unique case (phase_ff)
         prlp_pkg::PH_IMAGE: begin
            if (prlp_pkg::ends_number(byte_in)) begin
               phase_in = prlp_pkg::PH_SKIP;
            end else begin
               number_in = number_mac;
            end
         end
         prlp_pkg::PH_SKIP: begin
            if (byte_in == prlp_pkg::CHAR_SPACE) begin
               phase_in = prlp_pkg::PH_PORT;
            end
         end
         prlp_pkg::PH_PORT: begin
            if (prlp_pkg::ends_number(byte_in)) begin
               phase_in = prlp_pkg::PH_NEWLINES;
            end else begin
               port_in = port_mac;
            end
         end
         prlp_pkg::PH_NEWLINES: begin
            nl_in = nl_next;
            if (nl_next == prlp_pkg::NEWLINES_DONE) begin
               emit      = 1'b1;
               phase_in  = prlp_pkg::PH_PREFIX;
               pos_in    = '0;
               ok_in     = 1'b1;
               number_in = '0;
               port_in   = '0;
               nl_in     = '0;
            end
         end
         default: begin
            // prefix match; unused phase codes land here too
            ok_in = ok_next;
            if (pos_ff != prlp_pkg::PREFIX_LAST) begin
               pos_in = pos_ff + 2'd1;
            end else if (ok_next) begin
               phase_in  = prlp_pkg::PH_IMAGE;
               pos_in    = '0;
               number_in = '0;
               port_in   = '0;
               nl_in     = '0;
            end else begin
               emit      = 1'b1;
               result.status       = prlp_pkg::STATUS_REJECT;
               result.image_number = '0;
               result.reply_port   = '0;
               phase_in  = prlp_pkg::PH_PREFIX;
               pos_in    = '0;
               ok_in     = 1'b1;
               number_in = '0;
               port_in   = '0;
               nl_in     = '0;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= prlp_pkg::PH_PREFIX;
         pos_ff    <= '0;
         ok_ff     <= 1'b1;
         number_ff <= '0;
         port_ff   <= '0;
         nl_ff     <= '0;
      end else if (fire) begin
         phase_ff  <= phase_in;
         pos_ff    <= pos_in;
         ok_ff     <= ok_in;
         number_ff <= number_in;
         port_ff   <= port_in;
         nl_ff     <= nl_in;
      end
   end

endmodule

/* hw/rtl/push_request_line_parser_unit.sv */
// ----------------------------------------------------------------------------
// push_request_line_parser_unit: request line parser, one byte per item
// Parses "GET <image> <port>" followed by two LF bytes into one result item.
// ----------------------------------------------------------------------------
// Feed the request one byte per item on req_. The unit checks for the "GET "
// prefix, then collects a decimal image number up to a space, CR or LF, skips
// to the next space, collects a decimal port the same way, and after two more
// LF bytes returns one item with status 0, the image number and the port.
// A wrong prefix returns an item with status 1 and zero fields right after
// the fourth byte. Non-digit bytes inside a number count as digit 0, and both
// numbers saturate. The unit takes one byte every cycle while no byte is held
// back: a byte waits in the input register, is stepped through the parse state,
// and its result, if any, is shown on rsp_ the cycle after the step. Only a byte
// that makes a result waits while an earlier result has not been taken.
// ----------------------------------------------------------------------------
module push_request_line_parser_unit #(
   parameter int NUMBER_BITS = 32   // image number accumulator width, 8 to 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [prlp_pkg::BYTE_BITS-1:0]      req_tdata,   // [7:0] rx_byte
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [0] status, [32:1] image_number, [48:33] reply_port, [55:49] zero
   output logic [prlp_pkg::RSP_DATA_BITS-1:0]  rsp_tdata
);

   localparam int PAD_BITS = prlp_pkg::RSP_DATA_BITS - 1
                           - prlp_pkg::IMAGE_BITS - prlp_pkg::PORT_BITS;

   // input register
   logic                           in_valid_ff, in_valid_in;
   logic [prlp_pkg::BYTE_BITS-1:0] in_byte_ff,  in_byte_in;

   // result register
   logic                           rsp_valid_ff, rsp_valid_in;
   prlp_pkg::result_type           rsp_data_ff,  rsp_data_in;

   logic                           core_emit;
   prlp_pkg::result_type           core_result;
   logic                           out_free;
   logic                           fire;
   logic                           req_take;

   prlp_core #(.NUMBER_BITS(NUMBER_BITS)) u_core (
      .clock   (clock),
      .reset   (reset),
      .byte_in (in_byte_ff),
      .fire    (fire),
      .emit    (core_emit),
      .result  (core_result)
   );

   // Result slot is free when empty or drained this cycle
   assign out_free = !rsp_valid_ff || rsp_tready;
   // Step the held byte unless it makes a result with nowhere to go
   assign fire     = in_valid_ff && (out_free || !core_emit);
   assign req_tready = !in_valid_ff || fire;
   assign req_take   = req_tvalid && req_tready;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_tdata;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (fire && core_emit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = core_result;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload: load only, no reset
   always_ff @(posedge clock) begin
      in_byte_ff  <= in_byte_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{PAD_BITS{1'b0}}, rsp_data_ff.reply_port,
                        rsp_data_ff.image_number, rsp_data_ff.status};

   // A reject item never carries parsed values
   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.status == prlp_pkg::STATUS_REJECT) |->
      (rsp_data_ff.image_number == '0 && rsp_data_ff.reply_port == '0))
      else $error("reject item with nonzero fields");

   // A byte whose result is blocked stays in the input register
   a_hold_blocked: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && core_emit && !out_free) |=> (in_valid_ff && $stable(in_byte_ff)))
      else $error("blocked byte lost from input register");

   // A produced result shows up on the output next cycle
   a_emit_shown: assert property (@(posedge clock) disable iff (reset)
      (fire && core_emit) |=> rsp_valid_ff)
      else $error("produced result not presented");

   // An empty input register always takes a byte
   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      !in_valid_ff |-> req_tready)
      else $error("empty input register refused a byte");

endmodule

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for push_request_line_parser_unit
// Streams request bytes into the parser with random idles and stalls, predicts
// every reply from a behavioral copy of the parse state, and compares each
// reply item field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int BYTE_BITS     = prlp_pkg::BYTE_BITS;
   localparam int IMAGE_BITS    = prlp_pkg::IMAGE_BITS;
   localparam int PORT_BITS     = prlp_pkg::PORT_BITS;
   localparam int RSP_DATA_BITS = prlp_pkg::RSP_DATA_BITS;

   localparam int NUMBER_BITS = 32;
   localparam int IDLE_PCT    = 24;
   localparam int CALM_FROM   = 500;    // accepted bytes: start of the no-idle stretch
   localparam int CALM_UNTIL  = 800;
   localparam int RANDOM_BYTES = 1400;
   localparam int DRAIN_BYTES = 10;     // settle time after the last reply
   localparam bit [31:0] GET_WORD = "GET ";

   typedef struct {
      bit [BYTE_BITS-1:0] rx;
      bit                 hold;    // wait for all replies before sending
   } pending_item_type;

   typedef struct {
      bit                  status;
      bit [IMAGE_BITS-1:0] image_number;
      bit [PORT_BITS-1:0]  reply_port;
   } parse_reply_type;

   logic                     clock      = 1'b0;
   logic                     reset      = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [BYTE_BITS-1:0]     req_tdata  = '0;   // [7:0] rx_byte
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   // [0] status, [32:1] image_number, [48:33] reply_port, [55:49] zero
   logic [RSP_DATA_BITS-1:0] rsp_tdata;

   pending_item_type pending_bytes[$];
   parse_reply_type  expected_replies[$];
   bit               hold_next = 1'b0;
   int               accepted_bytes = 0;
   int               error_count = 0;
   pending_item_type next_item;
   parse_reply_type  head_reply;

   // Shadow of the parser state
   prlp_pkg::phase_type    parse_phase;
   bit [1:0]               prefix_pos;
   bit                     prefix_match;
   bit [63:0]              image_acc;
   bit [PORT_BITS-1:0]     port_acc;
   bit [1:0]               lf_count;

   push_request_line_parser_unit #(.NUMBER_BITS(NUMBER_BITS)) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   // ------------------------------------------------------------------
   // Parse prediction
   // ------------------------------------------------------------------
   function automatic bit is_delimiter(input bit [BYTE_BITS-1:0] b);
      return b == prlp_pkg::CHAR_SPACE || b == prlp_pkg::CHAR_LF || b == prlp_pkg::CHAR_CR;
   endfunction

   // Decimal accumulate, clamped at lim; a non-digit counts as zero
   function automatic bit [63:0] shift_in_digit(input bit [63:0] acc,
                                                input bit [BYTE_BITS-1:0] b,
                                                input bit [63:0] lim);
      bit [63:0] d;
      d = (b >= prlp_pkg::CHAR_ZERO && b <= prlp_pkg::CHAR_NINE)
          ? 64'(b - prlp_pkg::CHAR_ZERO) : 64'd0;
      if (acc > (lim - d) / 10) return lim;
      return acc * 10 + d;
   endfunction

   function automatic void clear_parser();
      parse_phase  = prlp_pkg::PH_PREFIX;
      prefix_pos   = '0;
      prefix_match = 1'b1;
      image_acc    = '0;
      port_acc     = '0;
      lf_count     = '0;
   endfunction

   // Advance the shadow state by one accepted byte; queue any reply it makes
   function automatic void parse_byte(input bit [BYTE_BITS-1:0] b);
      bit [63:0]       number_max;
      parse_reply_type r;
      number_max = {64{1'b1}} >> (64 - NUMBER_BITS);
      case (parse_phase)
         prlp_pkg::PH_IMAGE: begin
            if (is_delimiter(b)) parse_phase = prlp_pkg::PH_SKIP;
            else image_acc = shift_in_digit(image_acc, b, number_max);
         end
         prlp_pkg::PH_SKIP: begin
            if (b == prlp_pkg::CHAR_SPACE) parse_phase = prlp_pkg::PH_PORT;
         end
         prlp_pkg::PH_PORT: begin
            // the LF that ends the port is not one of the two closing LFs
            if (is_delimiter(b)) parse_phase = prlp_pkg::PH_NEWLINES;
            else port_acc = PORT_BITS'(shift_in_digit(64'(port_acc), b, 64'hFFFF));
         end
         prlp_pkg::PH_NEWLINES: begin
            if (b == prlp_pkg::CHAR_LF) lf_count++;
            if (lf_count >= prlp_pkg::NEWLINES_DONE) begin
               r.status       = prlp_pkg::STATUS_OK;
               r.image_number = (image_acc > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF
                                                             : image_acc[31:0];
               r.reply_port   = port_acc;
               expected_replies.push_back(r);
               clear_parser();
            end
         end
         default: begin
            // unused phase codes behave as the prefix check
            if (b != GET_WORD[31 - 8 * prefix_pos -: 8]) prefix_match = 1'b0;
            if (prefix_pos < prlp_pkg::PREFIX_LAST) begin
               prefix_pos++;
            end else if (prefix_match) begin
               clear_parser();
               parse_phase = prlp_pkg::PH_IMAGE;
            end else begin
               r.status       = prlp_pkg::STATUS_REJECT;
               r.image_number = '0;
               r.reply_port   = '0;
               expected_replies.push_back(r);
               clear_parser();
            end
         end
      endcase
   endfunction

   // ------------------------------------------------------------------
   // Stimulus building
   // ------------------------------------------------------------------
   function automatic void add_byte(input bit [BYTE_BITS-1:0] b);
      pending_item_type p;
      p.rx   = b;
      p.hold = hold_next;
      hold_next = 1'b0;
      pending_bytes.push_back(p);
   endfunction

   function automatic void add_text(input string s);
      for (int i = 0; i < s.len(); i++) add_byte(s[i]);
   endfunction

   // Any byte that ends no number
   function automatic bit [BYTE_BITS-1:0] rand_other();
      bit [BYTE_BITS-1:0] b;
      do b = BYTE_BITS'($urandom_range(255)); while (is_delimiter(b));
      return b;
   endfunction

   function automatic bit [BYTE_BITS-1:0] rand_delimiter();
      case ($urandom_range(2))
         0:       return prlp_pkg::CHAR_SPACE;
         1:       return prlp_pkg::CHAR_CR;
         default: return prlp_pkg::CHAR_LF;
      endcase
   endfunction

   function automatic void add_digits(input int n);
      repeat (n) begin
         if ($urandom_range(99) < 6) add_byte(rand_other());
         else add_byte(prlp_pkg::CHAR_ZERO + BYTE_BITS'($urandom_range(9)));
      end
   endfunction

   // One request: mostly well formed, some with a bad prefix or cut short
   function automatic void add_request();
      int k;
      bit [BYTE_BITS-1:0] b;
      if ($urandom_range(99) < 8) begin
         k = $urandom_range(3);
         for (int i = 0; i < 4; i++) begin
            b = (i == k) ? BYTE_BITS'($urandom_range(255))
                         : GET_WORD[31 - 8 * i -: 8];
            add_byte(b);
         end
         return;
      end
      add_text("GET ");
      add_digits(($urandom_range(9) == 0) ? $urandom_range(10, 14) : $urandom_range(0, 6));
      add_byte(rand_delimiter());
      repeat ($urandom_range(2)) add_byte(rand_other());
      add_byte(prlp_pkg::CHAR_SPACE);
      add_digits(($urandom_range(9) == 0) ? $urandom_range(6, 8) : $urandom_range(0, 5));
      add_byte(rand_delimiter());
      if ($urandom_range(99) < 3) return;   // truncated request
      k = 0;
      while (k < 2) begin
         if ($urandom_range(4) == 0) begin
            add_byte(rand_other());
         end else begin
            add_byte(prlp_pkg::CHAR_LF);
            k++;
         end
      end
   endfunction

   // ------------------------------------------------------------------
   // Driver: predict on acceptance, then load the next byte or idle
   // ------------------------------------------------------------------
   function automatic bit calm_stretch();
      return accepted_bytes >= CALM_FROM && accepted_bytes < CALM_UNTIL;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            parse_byte(req_tdata);
            accepted_bytes++;
         end
         if (!req_tvalid || req_tready) begin
            // hold a marked byte back until every reply has come out
            if (pending_bytes.size() != 0
                && !(pending_bytes[0].hold && expected_replies.size() != 0)
                && (calm_stretch() || $urandom_range(99) >= IDLE_PCT)) begin
               next_item = pending_bytes.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= next_item.rx;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Monitor: compare each reply item with the oldest prediction
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_replies.size() == 0) begin
               $display("%0t: unexpected reply item, actual %h", $time, rsp_tdata);
               error_count++;
            end else begin
               head_reply = expected_replies.pop_front();
               if (rsp_tdata[0] !== head_reply.status) begin
                  $display("%0t: status mismatch, expected %0d, actual %0d",
                           $time, head_reply.status, rsp_tdata[0]);
                  error_count++;
               end
               if (rsp_tdata[32:1] !== head_reply.image_number) begin
                  $display("%0t: image_number mismatch, expected %0d, actual %0d",
                           $time, head_reply.image_number, rsp_tdata[32:1]);
                  error_count++;
               end
               if (rsp_tdata[48:33] !== head_reply.reply_port) begin
                  $display("%0t: reply_port mismatch, expected %0d, actual %0d",
                           $time, head_reply.reply_port, rsp_tdata[48:33]);
                  error_count++;
               end
            end
         end
         rsp_tready <= calm_stretch() || $urandom_range(99) >= IDLE_PCT;
      end
   end

   // ------------------------------------------------------------------
   // Sequence: reset, directed requests, random requests, drain
   // ------------------------------------------------------------------
   initial begin
      clear_parser();
      // empty numbers, then both numbers at their exact maximum
      add_text("GET   \r\n\n");
      add_text("GET 4294967295 65535\n\n");
      // saturation of both numbers
      add_text("GET 99999999999 999999\n\n");
      // bad prefix on first and last byte
      add_text("XET ");
      add_text("GET!");
      // non-digit inside numbers, image ended by CR, skip bytes, port ended by LF
      add_text("GET 1a\rxx 7b\nq\n\n");
      // image ended by LF, port ended by space, noise between closing LFs
      add_text("GET 12\n 34 z\n\xff\n");
      hold_next = 1'b1;
      while (pending_bytes.size() < RANDOM_BYTES) begin
         if (pending_bytes.size() > RANDOM_BYTES / 2
             && pending_bytes.size() < RANDOM_BYTES / 2 + 20)
            hold_next = 1'b1;
         if ($urandom_range(99) < 5) begin
            repeat ($urandom_range(1, 2) * 4) add_byte(BYTE_BITS'($urandom_range(255)));
         end
         add_request();
      end
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      while (pending_bytes.size() != 0 || req_tvalid) @(posedge clock);
      while (expected_replies.size() != 0) @(posedge clock);
      repeat (DRAIN_BYTES) @(posedge clock);
      if (error_count == 0 && expected_replies.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // Watchdog, far above the slowest legal run
   initial begin
      #2_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

/* push_request_line_parser_unit.f */
hw/rtl/prlp_pkg.sv
hw/rtl/prlp_mac10.sv
hw/rtl/prlp_core.sv
hw/rtl/push_request_line_parser_unit.sv
tb/tb_top.sv
